FILE: hw/rtl/fsca_pkg.sv
// Package for the fixed-slot context allocator.
// Holds the pool geometry, the transaction structs, the sequencer states and helpers.
// No dependencies.
`default_nettype none

package fsca_pkg;

  // Pool geometry. SLOT_BYTES must be a power of two.
  localparam int SLOT_COUNT = 320;
  localparam int SLOT_BYTES = 64;
  localparam int SLOT_SHIFT = $clog2(SLOT_BYTES);

  // The used bitmap is stored as words of WORD_BITS slots each.
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int SCAN_W     = WORD_W + BIT_W;

  localparam int ADDR_W = 32;
  localparam int IDX_W  = 9;

  localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'h6001_0000;
  localparam logic [ADDR_W:0]   POOL_BYTES      = (ADDR_W + 1)'(SLOT_COUNT * SLOT_BYTES);
  localparam logic [WORD_W-1:0] LAST_WORD       = WORD_W'(WORD_COUNT - 1);

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_RESET  = 2'd3
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [ADDR_W-1:0] address;
  } request_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] context_address;
    logic [IDX_W-1:0]  slot_index;
    logic              clear_context;
    logic              reset_decoder;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOCATE = 2'd1,
    ST_EVAL   = 2'd2
  } state_t;

  // Outcome of the address range and alignment check.
  typedef struct packed {
    logic              hit;
    logic [SCAN_W-1:0] slot;
  } locate_t;

  // Write port of the bitmap memory.
  typedef struct packed {
    logic                 en;
    logic [WORD_W-1:0]    addr;
    logic [WORD_BITS-1:0] data;
  } bitmap_wr_t;

  // Slot number in the width of the result field.
  function automatic logic [IDX_W-1:0] to_idx(input logic [SCAN_W-1:0] slot);
    logic [SCAN_W+IDX_W-1:0] wide;
    wide = {{IDX_W{1'b0}}, slot};
    return wide[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fsca_bitmap_mem.sv
// Used-slot bitmap memory of the context allocator, one word of slots per row.
// Rows carry a valid flag cleared by reset; an unwritten row reads as all free.
// Depends on fsca_pkg.
`default_nettype none

module fsca_bitmap_mem
  import fsca_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [WORD_W-1:0]    rd_addr,
  input  wire bitmap_wr_t           wr,
  output logic      [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0]  mem [WORD_COUNT];
  logic [WORD_BITS-1:0]  mem_q;
  logic [WORD_COUNT-1:0] row_valid;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr.en) begin
        row_valid[wr.addr] <= 1'b1;
      end
      rd_valid <= row_valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? mem_q : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/fsca_slot_decode.sv
// Address decoder of the context allocator.
// Checks that an address lies in the pool and is slot-aligned, and gives its slot number.
// Depends on fsca_pkg.
`default_nettype none

module fsca_slot_decode
  import fsca_pkg::*;
(
  input  wire logic [ADDR_W-1:0] pool_base,
  input  wire logic [ADDR_W-1:0] address,
  output locate_t                loc
);

  logic [ADDR_W:0] offset;
  logic            below_base;
  logic            in_pool;
  logic            aligned;

  always_comb begin
    offset     = {1'b0, address} - {1'b0, pool_base};
    below_base = offset[ADDR_W];
    in_pool    = !below_base && (offset < POOL_BYTES);
    aligned    = (offset[SLOT_SHIFT-1:0] == '0);
    loc.hit    = (pool_base != '0) && in_pool && aligned;
    loc.slot   = offset[SLOT_SHIFT +: SCAN_W];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fixed_slot_context_allocator.sv
// Top level of the fixed-slot context allocator.
// Instantiates fsca_slot_decode and fsca_bitmap_mem; depends on fsca_pkg.
//
// Usage:
// The allocator hands out fixed-size context slots from a pool that starts at
// pool_base. A command transaction is taken at a rising edge where start is
// high and busy is low; request carries the action and, for free, query and
// reset, the context address. Each command yields exactly one result
// transaction: result_valid is high for one cycle with result, and the
// receiver must take it then, since there is no back-pressure.
//
// Timing: free, query and reset pass through the LOCATE and EVAL states after
// the accepting edge, and busy drops in the same cycle as result_valid rises,
// so a new command is taken only once the last one has answered. Create scans
// the used bitmap one word of 32 slots per cycle through the single read port
// of the bitmap memory, from word zero up to the first word with a free slot
// or the last word.
//
// The user must write pool_base via pool_base_we and pool_base_data while the
// block is idle; the block does not enforce it. Reset restores pool_base and
// invalidates every bitmap row at once (all slots read free; no clearing pass).
`default_nettype none

module fixed_slot_context_allocator
  import fsca_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire request_t          request,
  output logic                   result_valid,
  output result_t                result,
  input  wire logic              pool_base_we,
  input  wire logic [ADDR_W-1:0] pool_base_data
);

  state_t state, state_next;

  // Captured command and decode results.
  action_t           op;
  logic [ADDR_W-1:0] addr_q;
  logic              hit;
  logic [SCAN_W-1:0] slot_q;
  logic [WORD_W-1:0] scan_word, scan_word_next;
  logic [ADDR_W-1:0] pool_base;

  // Memory interface.
  logic [WORD_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  bitmap_wr_t           wr;

  locate_t loc;

  // Evaluation signals.
  logic [WORD_BITS-1:0] free_vec;
  logic [BIT_W-1:0]     free_bit;
  logic [SCAN_W-1:0]    new_slot;
  logic [ADDR_W:0]      new_addr;
  logic                 create_ok;
  logic                 scan_more;
  logic [BIT_W-1:0]     bit_sel;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 slot_in_use;
  result_t              result_next;
  logic                 result_load;

  fsca_slot_decode u_decode (
    .pool_base (pool_base),
    .address   (addr_q),
    .loc       (loc)
  );

  fsca_bitmap_mem u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (rd_data)
  );

  // Search of the word in hand for the lowest free slot. Bits past the last
  // slot of the pool count as taken.
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      free_vec[b] = !rd_data[b] &&
                    ({scan_word, BIT_W'(b)} < SCAN_W'(SLOT_COUNT));
    end
    free_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        free_bit = BIT_W'(b);
      end
    end
    new_slot  = {scan_word, free_bit};
    new_addr  = {1'b0, pool_base} + ((ADDR_W + 1)'(new_slot) << SLOT_SHIFT);
    // A slot whose address would pass 4 GiB does not exist, so create fails.
    create_ok = (pool_base != '0) && (|free_vec) && !new_addr[ADDR_W];
    scan_more = (pool_base != '0) && !(|free_vec) && (scan_word != LAST_WORD);

    bit_sel     = slot_q[BIT_W-1:0];
    bit_mask    = WORD_BITS'(1) << bit_sel;
    slot_in_use = rd_data[bit_sel];
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_LOCATE;
        end
      end
      ST_LOCATE: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (!((op == ACT_CREATE) && scan_more)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output and datapath control: memory accesses and the result.
  always_comb begin
    busy           = (state != ST_IDLE);
    rd_addr        = scan_word;
    scan_word_next = scan_word;
    wr             = '0;
    result_next    = '0;
    result_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        scan_word_next = '0;
      end
      ST_LOCATE: begin
        // Create starts its scan at word zero; the others read their slot's word on a hit.
        if ((op != ACT_CREATE) && loc.hit) begin
          rd_addr = loc.slot[SCAN_W-1:BIT_W];
        end else begin
          rd_addr = '0;
        end
        scan_word_next = '0;
      end
      ST_EVAL: begin
        case (op)
          ACT_CREATE: begin
            if (scan_more) begin
              scan_word_next = scan_word + WORD_W'(1);
              rd_addr        = scan_word_next;
            end else begin
              result_load = 1'b1;
              if (create_ok) begin
                wr.en                       = 1'b1;
                wr.addr                     = scan_word;
                wr.data                     = rd_data | (WORD_BITS'(1) << free_bit);
                result_next.ok              = 1'b1;
                result_next.context_address = new_addr[ADDR_W-1:0];
                result_next.slot_index      = to_idx(new_slot);
                result_next.clear_context   = 1'b1;
              end
            end
          end
          ACT_FREE: begin
            result_load = 1'b1;
            if (hit && slot_in_use) begin
              wr.en                     = 1'b1;
              wr.addr                   = slot_q[SCAN_W-1:BIT_W];
              wr.data                   = rd_data & ~bit_mask;
              result_next.ok            = 1'b1;
              result_next.slot_index    = to_idx(slot_q);
              result_next.clear_context = 1'b1;
              result_next.reset_decoder = 1'b1;
            end
          end
          ACT_QUERY: begin
            result_load = 1'b1;
            if (hit && slot_in_use) begin
              result_next.ok         = 1'b1;
              result_next.slot_index = to_idx(slot_q);
            end
          end
          ACT_RESET: begin
            // Only range and alignment matter; the use mark is not consulted.
            result_load = 1'b1;
            if (hit) begin
              result_next.ok            = 1'b1;
              result_next.slot_index    = to_idx(slot_q);
              result_next.reset_decoder = 1'b1;
            end
          end
          default: begin
            result_load = 1'b1;
          end
        endcase
      end
      default: begin
        scan_word_next = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      pool_base    <= POOL_BASE_RESET;
    end else begin
      state        <= state_next;
      result_valid <= result_load;
      if (pool_base_we) begin
        pool_base <= pool_base_data;
      end
    end
  end

  // Command and result registers.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      op     <= request.action;
      addr_q <= request.address;
    end
    if (state == ST_LOCATE) begin
      hit    <= loc.hit;
      slot_q <= loc.slot;
    end
    scan_word <= scan_word_next;
    if (result_load) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fsca_checker.sv
// Port-level checker of the fixed-slot context allocator, with its bind statement.
// Depends on fsca_pkg and the fixed_slot_context_allocator top level.
`default_nettype none

module fsca_checker
  import fsca_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    result_valid,
  input wire result_t result
);

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result only ends a command: it follows a busy cycle and frees the block.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(busy) && !busy))
    else $error("result transaction without a command in flight");

  // A failed operation reports all fields as zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.ok) |->
      (result.context_address == '0 && result.slot_index == '0 &&
       !result.clear_context && !result.reset_decoder))
    else $error("failed result carries nonzero fields");

  // Clear and decoder-reset requests come only with success, and a created
  // slot always has a nonzero address.
  a_request_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.clear_context || result.reset_decoder)) |->
      (result.ok && (result.reset_decoder || result.context_address != '0)))
    else $error("clear or reset request on an unsuccessful result");

endmodule

bind fixed_slot_context_allocator fsca_checker u_fsca_checker (.*);

`default_nettype wire

FILE: test/fixed_slot_context_allocator_test.sv
// Self-checking testbench for fixed_slot_context_allocator: directed table, then random phases.
// Uses fsca_pkg for the command and result structs and for the pool geometry.
`timescale 1ns / 1ps

module fixed_slot_context_allocator_test;
  import fsca_pkg::*;

  // Stimulus side. Every input has a known value from time zero, and reset is
  // held from the start.
  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              start          = 1'b0;
  request_t          request        = '0;
  logic              pool_base_we   = 1'b0;
  logic [ADDR_W-1:0] pool_base_data = '0;
  logic              busy;
  logic              result_valid;
  result_t           result;

  fixed_slot_context_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request        (request),
    .result_valid   (result_valid),
    .result         (result),
    .pool_base_we   (pool_base_we),
    .pool_base_data (pool_base_data)
  );

  // 8 ns clock, 4 ns high and 4 ns low.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The testbench keeps its own copy of the allocator state: the base address
  // of slot zero and one used mark per slot. Both change only when a command
  // transaction is accepted or when the base register is written.
  logic [ADDR_W-1:0] base_addr = POOL_BASE_RESET;
  bit                slot_taken [SLOT_COUNT];

  // Results owed by the block, oldest first. Every command yields exactly one.
  result_t answers_due [$];
  int      error_count = 0;

  localparam result_t NO_ANSWER = '0;

  // Maps an address to a slot number when it falls inside the pool and sits on
  // a slot boundary. Nothing matches while the base is zero.
  function automatic bit pool_slot_of(input logic [ADDR_W-1:0] addr,
                                      output int unsigned slot);
    logic [ADDR_W-1:0] offset;
    slot = 0;
    if (base_addr == '0 || addr < base_addr) return 1'b0;
    offset = addr - base_addr;
    if (offset >= ADDR_W'(SLOT_COUNT * SLOT_BYTES)) return 1'b0;
    if (offset % SLOT_BYTES != 0) return 1'b0;
    slot = offset / SLOT_BYTES;
    return 1'b1;
  endfunction

  // Works out the answer to one command and applies its effect on the used
  // marks. Any failed check answers with every field zero.
  function automatic result_t allocator_answer(input request_t cmd);
    result_t     ans;
    int unsigned slot;
    logic [63:0] where;
    ans  = '0;
    slot = 0;
    case (cmd.action)
      ACT_CREATE: begin
        if (base_addr != '0) begin
          while (slot < SLOT_COUNT && slot_taken[slot]) slot++;
          where = {32'h0, base_addr} + 64'(slot) * 64'(SLOT_BYTES);
          // A full pool, or a lowest free slot that would lie past 4 GiB,
          // leaves the answer empty and the marks untouched.
          if (slot < SLOT_COUNT && where <= 64'hFFFF_FFFF) begin
            slot_taken[slot]    = 1'b1;
            ans.ok              = 1'b1;
            ans.context_address = where[ADDR_W-1:0];
            ans.slot_index      = IDX_W'(slot);
            ans.clear_context   = 1'b1;
          end
        end
      end
      ACT_FREE: begin
        if (pool_slot_of(cmd.address, slot) && slot_taken[slot]) begin
          slot_taken[slot]  = 1'b0;
          ans.ok            = 1'b1;
          ans.slot_index    = IDX_W'(slot);
          ans.clear_context = 1'b1;
          ans.reset_decoder = 1'b1;
        end
      end
      ACT_QUERY: begin
        if (pool_slot_of(cmd.address, slot) && slot_taken[slot]) begin
          ans.ok         = 1'b1;
          ans.slot_index = IDX_W'(slot);
        end
      end
      ACT_RESET: begin
        // Range and alignment only; the used mark is neither read nor changed.
        if (pool_slot_of(cmd.address, slot)) begin
          ans.ok            = 1'b1;
          ans.slot_index    = IDX_W'(slot);
          ans.reset_decoder = 1'b1;
        end
      end
    endcase
    return ans;
  endfunction

  // Picks a slot number, half the time a slot that is currently taken so that
  // free and query commands find something to act on.
  function automatic int unsigned pick_slot();
    int unsigned first;
    int unsigned s;
    first = $urandom_range(0, SLOT_COUNT - 1);
    if ($urandom_range(0, 1) == 1) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        s = (first + k) % SLOT_COUNT;
        if (slot_taken[s]) return s;
      end
    end
    return first;
  endfunction

  // Addresses for free, query and reset. Most are slot boundaries inside the
  // pool; the rest probe misalignment, both pool edges and arbitrary values.
  function automatic logic [ADDR_W-1:0] command_address();
    logic [ADDR_W-1:0] addr;
    int                roll;
    roll = $urandom_range(0, 99);
    addr = base_addr + ADDR_W'(pick_slot() * SLOT_BYTES);
    if (roll < 75) return addr;
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return addr + ADDR_W'($urandom_range(1, SLOT_BYTES - 1));
      2:       return base_addr - ADDR_W'(SLOT_BYTES * $urandom_range(1, 4));
      3:       return base_addr + ADDR_W'(SLOT_COUNT * SLOT_BYTES)
                      + ADDR_W'(SLOT_BYTES * $urandom_range(0, 3));
      4:       return '0;
      default: return '1;
    endcase
  endfunction

  // Presents one command from the falling edge on and holds it until a rising
  // edge finds busy low. At that edge the transaction is taken, so that is
  // where the owed answer is queued. A typed answer from the directed table
  // replaces the computed one, but the state is always advanced.
  task automatic send_command(input request_t cmd, input bit typed,
                              input result_t typed_answer);
    result_t predicted;
    @(negedge clk);
    start   <= 1'b1;
    request <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = allocator_answer(cmd);
    answers_due.push_back(typed ? typed_answer : predicted);
  endtask

  // Sender gaps: mostly none or a few cycles, now and then a long one. Gaps
  // start right after acceptance, so they land on every cycle of the work.
  task automatic pause_sender(input bit calm);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // The base register is written only with nothing in flight. Every command
  // answers, so an empty queue means the block is idle; a few extra cycles
  // are allowed anyway before the write.
  task automatic set_pool_base(input logic [ADDR_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    pool_base_we   <= 1'b1;
    pool_base_data <= value;
    @(negedge clk);
    pool_base_we <= 1'b0;
    base_addr = value;
  endtask

  // One random phase at a given base. The mix of actions sets whether the
  // pool fills up or drains; stretches of 64 commands run back to back at
  // random.
  task automatic run_phase(input logic [ADDR_W-1:0] base, input int items,
                           input int create_pct, input int free_pct);
    request_t cmd;
    int       roll;
    bit       calm;
    set_pool_base(base);
    calm = 1'b0;
    for (int n = 0; n < items; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < create_pct) cmd.action = ACT_CREATE;
      else if (roll < create_pct + free_pct) cmd.action = ACT_FREE;
      else if ($urandom_range(0, 1) == 1) cmd.action = ACT_QUERY;
      else cmd.action = ACT_RESET;
      // Create ignores the address, so it carries arbitrary bits.
      cmd.address = (cmd.action == ACT_CREATE) ? $urandom() : command_address();
      send_command(cmd, 1'b0, NO_ANSWER);
      pause_sender(calm);
    end
  endtask

  // Directed table. Rows either write the base register or issue a command.
  // Answers are typed in where they are obvious; other rows are left to the
  // computed answer.
  typedef enum bit {ROW_COMMAND, ROW_BASE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    action_t           op;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    result_t           answer;
  } plan_row_t;

  localparam int PLAN_LEN = 26;

  plan_row_t plan [PLAN_LEN] = '{
    // Default base, empty pool: nothing owned yet.
    '{ROW_COMMAND, ACT_QUERY,  32'h6001_0000, 1'b1, NO_ANSWER},
    // The first two creates take slots zero and one.
    '{ROW_COMMAND, ACT_CREATE, 32'h0000_0000, 1'b1,
      result_t'{1'b1, 32'h6001_0000, 9'd0, 1'b1, 1'b0}},
    '{ROW_COMMAND, ACT_CREATE, 32'hFFFF_FFFF, 1'b1,
      result_t'{1'b1, 32'h6001_0040, 9'd1, 1'b1, 1'b0}},
    '{ROW_COMMAND, ACT_QUERY,  32'h6001_0040, 1'b1,
      result_t'{1'b1, 32'h0, 9'd1, 1'b0, 1'b0}},
    // Misaligned, and one slot below the pool.
    '{ROW_COMMAND, ACT_QUERY,  32'h6001_0041, 1'b1, NO_ANSWER},
    '{ROW_COMMAND, ACT_QUERY,  32'h6000_FFC0, 1'b1, NO_ANSWER},
    // Reset of the last slot passes without the slot being taken; one past
    // the end fails.
    '{ROW_COMMAND, ACT_RESET,  32'h6001_4FC0, 1'b1,
      result_t'{1'b1, 32'h0, 9'd319, 1'b0, 1'b1}},
    '{ROW_COMMAND, ACT_RESET,  32'h6001_5000, 1'b1, NO_ANSWER},
    // Free succeeds once, then finds the slot no longer in use.
    '{ROW_COMMAND, ACT_FREE,   32'h6001_0000, 1'b1,
      result_t'{1'b1, 32'h0, 9'd0, 1'b1, 1'b1}},
    '{ROW_COMMAND, ACT_FREE,   32'h6001_0000, 1'b1, NO_ANSWER},
    // Create reuses the lowest free slot.
    '{ROW_COMMAND, ACT_CREATE, 32'h5555_AAAA, 1'b1,
      result_t'{1'b1, 32'h6001_0000, 9'd0, 1'b1, 1'b0}},
    '{ROW_COMMAND, ACT_FREE,   32'hFFFF_FFFF, 1'b1, NO_ANSWER},
    '{ROW_COMMAND, ACT_QUERY,  32'h0000_0000, 1'b1, NO_ANSWER},
    '{ROW_COMMAND, ACT_RESET,  32'h6001_0020, 1'b1, NO_ANSWER},
    // No pool: create, reset and query all answer empty.
    '{ROW_BASE,    ACT_CREATE, 32'h0000_0000, 1'b0, NO_ANSWER},
    '{ROW_COMMAND, ACT_CREATE, 32'h0000_0000, 1'b1, NO_ANSWER},
    '{ROW_COMMAND, ACT_RESET,  32'h0000_0000, 1'b1, NO_ANSWER},
    '{ROW_COMMAND, ACT_QUERY,  32'h0000_0000, 1'b1, NO_ANSWER},
    // Highest base: the bitmap is kept, and only slots 0 to 63 fit below 4 GiB.
    '{ROW_BASE,    ACT_CREATE, 32'hFFFF_F000, 1'b0, NO_ANSWER},
    '{ROW_COMMAND, ACT_CREATE, 32'h0000_0000, 1'b1,
      result_t'{1'b1, 32'hFFFF_F080, 9'd2, 1'b1, 1'b0}},
    '{ROW_COMMAND, ACT_QUERY,  32'hFFFF_F040, 1'b1,
      result_t'{1'b1, 32'h0, 9'd1, 1'b0, 1'b0}},
    '{ROW_COMMAND, ACT_RESET,  32'hFFFF_FFC0, 1'b1,
      result_t'{1'b1, 32'h0, 9'd63, 1'b0, 1'b1}},
    '{ROW_COMMAND, ACT_FREE,   32'hFFFF_F080, 1'b1,
      result_t'{1'b1, 32'h0, 9'd2, 1'b1, 1'b1}},
    // Unaligned base is taken as it is.
    '{ROW_BASE,    ACT_CREATE, 32'h1234_5677, 1'b0, NO_ANSWER},
    '{ROW_COMMAND, ACT_QUERY,  32'h1234_5677, 1'b1,
      result_t'{1'b1, 32'h0, 9'd0, 1'b0, 1'b0}},
    '{ROW_COMMAND, ACT_CREATE, 32'hAAAA_5555, 1'b0, NO_ANSWER}
  };

  // Result checking. A result is valid for exactly one cycle and is taken at
  // the rising edge that ends it; it is matched against the oldest answer owed.
  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("t=%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (answers_due.size() == 0) begin
        $display("t=%0t: result transaction with nothing outstanding, expected none, actual %h",
                 $time, result);
        error_count++;
      end else begin
        want = answers_due.pop_front();
        compare_field("ok",              32'(want.ok),            32'(result.ok));
        compare_field("context_address", want.context_address,    result.context_address);
        compare_field("slot_index",      32'(want.slot_index),    32'(result.slot_index));
        compare_field("clear_context",   32'(want.clear_context), 32'(result.clear_context));
        compare_field("reset_decoder",   32'(want.reset_decoder), 32'(result.reset_decoder));
      end
    end
  end

  // Main sequence: reset, the directed table, then random phases that cover
  // the default base, a pool driven full, no pool, the highest base (slots
  // past 4 GiB), a pool ending exactly at 4 GiB, an unaligned base and a
  // random aligned base.
  initial begin
    request_t cmd;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_BASE) begin
        set_pool_base(plan[i].addr);
      end else begin
        cmd.action  = plan[i].op;
        cmd.address = plan[i].addr;
        send_command(cmd, plan[i].typed, plan[i].answer);
        pause_sender(1'b0);
      end
    end

    run_phase(POOL_BASE_RESET, 300, 50, 15);
    run_phase(POOL_BASE_RESET, 350, 85, 5);
    run_phase(32'h0000_0000,    40, 40, 20);
    run_phase(32'hFFFF_F000,   150, 40, 20);
    run_phase(32'hFFFF_B000,   150, 15, 55);
    run_phase($urandom_range(1, 32'hFFFF_F000), 150, 35, 30);
    run_phase({20'($urandom_range(1, 20'hF_FFFF)), 12'h000}, 150, 35, 30);
    run_phase(POOL_BASE_RESET,  60, 30, 30);

    // Stop sending, collect what is still owed and give a stray result time
    // to show up.
    @(negedge clk);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS fixed_slot_context_allocator");
    end else begin
      $display("FAIL fixed_slot_context_allocator");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAIL fixed_slot_context_allocator");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fsca_pkg.sv
hw/rtl/fsca_bitmap_mem.sv
hw/rtl/fsca_slot_decode.sv
hw/rtl/fixed_slot_context_allocator.sv
hw/rtl/fsca_checker.sv
test/fixed_slot_context_allocator_test.sv
